// ===== src/utf_tok_pkg.sv =====
// utf_tok_pkg: shared types, constants and byte classification for the
// utf-8 word / punctuation tokenizer; no dependencies
`default_nettype none

package utf_tok_pkg;

    localparam int BYTE_W = 8;
    localparam int CNT_W  = 2;

    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_CODE  = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD_CODE  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hF0;
    localparam logic [BYTE_W-1:0] CH_HYPHEN  = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_APOS    = 8'h27;
    localparam logic [BYTE_W-1:0] CH_UNDER   = 8'h5F;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;

    typedef struct packed {
        logic             is_space;
        logic             is_word;
        logic             is_lead;
        logic             is_cont;
        logic [CNT_W-1:0] lead_cnt;
    } t_byte_class;

    typedef struct packed {
        logic             inside_word;
        logic [CNT_W-1:0] cont_left;
    } t_tok_state;

    typedef struct packed {
        logic in_token;
        logic token_start;
    } t_tok_flags;

    function automatic t_byte_class classify_byte(input logic [BYTE_W-1:0] c);
        t_byte_class cls;
        cls.is_space = (c == CH_SPACE) || (c inside {[8'h09:8'h0D]});
        cls.is_word  = (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) ||
                       (c == CH_HYPHEN) || (c == CH_APOS) || (c == CH_UNDER);
        cls.is_lead  = (c & CONT_MASK) == LEAD_CODE;
        cls.is_cont  = (c & CONT_MASK) == CONT_CODE;
        if ((c & LEAD2_MASK) == LEAD_CODE) begin
            cls.lead_cnt = 2'd1;
        end else if ((c & LEAD3_MASK) == LEAD3_CODE) begin
            cls.lead_cnt = 2'd2;
        end else if ((c & LEAD4_MASK) == LEAD4_CODE) begin
            cls.lead_cnt = 2'd3;
        end else begin
            cls.lead_cnt = 2'd0;
        end
        return cls;
    endfunction

endpackage

`default_nettype wire

// ===== src/utf_tok_ifs.sv =====
// utf_tok_in_if / utf_tok_out_if: valid-ready channels of the tokenizer
// depends on utf_tok_pkg
`default_nettype none

interface utf_tok_in_if;
    import utf_tok_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface utf_tok_out_if;
    import utf_tok_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_out;
    logic              in_token;
    logic              token_start;
    logic              last_out;

    modport source (output valid, output byte_out, output in_token,
                    output token_start, output last_out, input ready);
    modport sink   (input valid, input byte_out, input in_token,
                    input token_start, input last_out, output ready);
endinterface

`default_nettype wire

// ===== src/utf_tok_step.sv =====
// utf_tok_step: per-byte token decision and next tokenizer state
// depends on utf_tok_pkg
`default_nettype none

module utf_tok_step
    import utf_tok_pkg::*;
(
    input  wire logic [BYTE_W-1:0] i_byte,
    input  wire logic              i_last,
    input  wire logic              i_lead_mode,
    input  wire t_tok_state        i_state,
    output t_tok_flags             o_flags,
    output t_tok_state             o_state
);

    t_byte_class cls;
    t_tok_state  nxt;
    logic        done;

    always_comb begin
        cls = classify_byte(i_byte);
        nxt.inside_word = i_state.inside_word;
        nxt.cont_left   = '0;
        o_flags         = '0;
        done            = 1'b0;

        // pending continuation bytes of a multi-byte character
        if (i_state.inside_word && (i_state.cont_left != '0) && cls.is_cont) begin
            nxt.cont_left    = i_state.cont_left - 2'd1;
            o_flags.in_token = 1'b1;
            done             = 1'b1;
        end

        if (!done && i_state.inside_word) begin
            if (cls.is_word) begin
                o_flags.in_token = 1'b1;
                done             = 1'b1;
            end else if (cls.is_lead) begin
                nxt.cont_left    = cls.lead_cnt;
                o_flags.in_token = 1'b1;
                done             = 1'b1;
            end else begin
                nxt.inside_word = 1'b0;
            end
        end

        if (!done) begin
            if (cls.is_space) begin
                o_flags = '0;
            end else if (cls.is_word) begin
                nxt.inside_word = 1'b1;
                o_flags         = '{in_token: 1'b1, token_start: 1'b1};
            end else if (cls.is_lead && i_lead_mode) begin
                nxt.inside_word = 1'b1;
                nxt.cont_left   = cls.lead_cnt;
                o_flags         = '{in_token: 1'b1, token_start: 1'b1};
            end else begin
                // punctuation, stray continuation byte included
                o_flags = '{in_token: 1'b1, token_start: 1'b1};
            end
        end

        if (i_last) begin
            nxt = '0;
        end
        o_state = nxt;
    end

endmodule

`default_nettype wire

// ===== src/utf8_word_punct_tokenizer_core.sv =====
// utf8_word_punct_tokenizer_core: top level, input register, state and result register
// depends on utf_tok_pkg, utf_tok_ifs, utf_tok_step
//
// Usage:
//   i_in_ch takes one text byte per item with end_of_text marking the last
//   byte of a text; o_out_ch gives exactly one result per byte: the byte,
//   whether it lies in a token, whether it starts one, and end_of_text.
//   i_cfg_we / i_cfg_wdata write the lead-byte mode bit (reset 1: a utf-8
//   lead byte may open a word; 0: it is punctuation outside a word).
// Timing:
//   an item accepted lands in the input register, is classified and moves
//   to the result register once that is free or being emptied; its result
//   is offered from then on. One item per cycle sustained while results are
//   taken; the only loop is the three-bit tokenizer state (word flag and
//   two-bit continuation count) updated as an item leaves the input register.
// Reset (synchronous, active low): both registers empty, tokenizer state
//   cleared, mode bit set.
// Stall: while the result is not taken the input register still takes one
//   more item, then i_in_ch.ready drops until the result moves on.
`default_nettype none

module utf8_word_punct_tokenizer_core
    import utf_tok_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    utf_tok_in_if.sink       i_in_ch,
    utf_tok_out_if.source    o_out_ch
);

    logic              r_lead_mode;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;
    t_tok_state        r_state;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    t_tok_flags        r_out_flags;
    logic              r_out_last;

    t_tok_state        n_state;
    t_tok_flags        n_flags;
    logic              advance;
    logic              in_take;

    assign advance        = r_in_valid && (!r_out_valid || o_out_ch.ready);
    assign i_in_ch.ready  = !r_in_valid || advance;
    assign in_take        = i_in_ch.valid && i_in_ch.ready;

    utf_tok_step u_step (
        .i_byte      (r_in_byte),
        .i_last      (r_in_last),
        .i_lead_mode (r_lead_mode),
        .i_state     (r_state),
        .o_flags     (n_flags),
        .o_state     (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead_mode <= 1'b1;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_lead_mode <= i_cfg_wdata;
            end
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_in_ch.text_byte;
            r_in_last <= i_in_ch.end_of_text;
        end
        if (advance) begin
            r_out_byte  <= r_in_byte;
            r_out_flags <= n_flags;
            r_out_last  <= r_in_last;
        end
    end

    assign o_out_ch.valid       = r_out_valid;
    assign o_out_ch.byte_out    = r_out_byte;
    assign o_out_ch.in_token    = r_out_flags.in_token;
    assign o_out_ch.token_start = r_out_flags.token_start;
    assign o_out_ch.last_out    = r_out_last;

    a_cont_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.cont_left != '0) |-> r_state.inside_word)
        else $error("continuation count pending outside a word");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |=> (r_state == '0))
        else $error("tokenizer state not cleared after end of text");

    a_space_no_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_flags.in_token) |-> !r_out_flags.token_start)
        else $error("skipped byte marked as token start");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("held input item lost or overwritten");

endmodule

`default_nettype wire
